/* rtl/fswl_pkg.sv */
package fswl_pkg;

  // Default sector count; the top level hands its parameter down.
  localparam int unsigned NUM_SECTORS_DEF = 4;

  localparam logic [31:0] HDR_MAGIC = 32'h224e8d1e;

  // Stream widths; the tdata widths are padded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 256;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 152;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_ALLOC  = 2'd2
  } cmd_e;

  // Datapath operations, issued one per cycle by the controller.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CUR_CLR,
    OP_CUR_ITEM,
    OP_CUR_HOLD,
    OP_HOLD,
    OP_BEST_CLR,
    OP_CAND,
    OP_PREP,
    OP_CK_WEAR,
    OP_CK_VER,
    OP_CK_FIN,
    OP_WR_LOAD,
    OP_WR_ALLOC,
    OP_RES
  } op_e;

  typedef struct packed {
    logic capture;
    op_e  op;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  sector_sel;
    logic [6:0]  device_address;
    logic [31:0] header_magic;
    logic [63:0] header_wear;
    logic [63:0] header_version;
    logic [63:0] header_pad;
    logic [15:0] header_sum;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  sector_out;
    logic [63:0] wear_out;
    logic [63:0] version_out;
    logic [15:0] checksum_out;
  } result_t;

  typedef struct packed {
    logic [6:0]  addr;
    logic [63:0] version;
    logic [63:0] wear;
  } entry_t;

  // 16-bit sum of the eight bytes of a word.
  function automatic logic [15:0] byte_sum64(input logic [63:0] v);
    logic [15:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 16'(v[8*i +: 8]);
    end
    return s;
  endfunction

  localparam logic [15:0] MAGIC_SUM = byte_sum64({32'd0, HDR_MAGIC});

endpackage

/* rtl/fswl_dpath.sv */
module fswl_dpath #(
  parameter int unsigned NUM_SECTORS = fswl_pkg::NUM_SECTORS_DEF,
  localparam int unsigned IdxW = $clog2(NUM_SECTORS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fswl_pkg::ctl_cmd_t ctl_cmd_i,
  input  logic [IdxW-1:0]    rd_idx_i,
  input  fswl_pkg::item_t    item_i,
  output fswl_pkg::cmd_e     item_cmd_o,
  output fswl_pkg::result_t  res_o
);

  fswl_pkg::item_t   item_q;
  fswl_pkg::op_e     op_q;
  logic [IdxW-1:0]   idx_q;

  // Sector table: address, version and wear in memory, valid marks in flops.
  fswl_pkg::entry_t  entry_mem [NUM_SECTORS];
  fswl_pkg::entry_t  rd_q;
  logic [NUM_SECTORS-1:0] valid_q;

  // Running "current version" search for one key address.
  logic              cur_found_q;
  logic [63:0]       cur_ver_q;
  logic [63:0]       cur_wear_q;
  logic [IdxW-1:0]   cur_idx_q;
  logic              first_found_q;
  logic [IdxW-1:0]   first_idx_q;

  // Sector under test in the candidate pass.
  fswl_pkg::entry_t  hold_q;
  logic [IdxW-1:0]   hold_idx_q;

  logic              best_found_q;
  logic [63:0]       best_wear_q;
  logic [IdxW-1:0]   best_first_q;
  logic [IdxW-1:0]   best_idx_q;

  logic [IdxW-1:0]   pick_q;
  logic              alloc_ok_q;
  logic [63:0]       new_ver_q;
  logic [63:0]       new_wear_q;
  logic [15:0]       ck_q;
  logic              load_ok_q;
  fswl_pkg::result_t res_q;
  fswl_pkg::result_t res_d;

  logic [6:0]        key_addr;
  logic              addr_hit;
  logic              ver_hit;
  logic              any_inv;
  logic [IdxW-1:0]   first_inv;
  logic              sel_in_range;
  logic [IdxW-1:0]   sel_idx;
  logic              is_load;
  logic [63:0]       ck_wear_src;
  logic [63:0]       ck_ver_src;
  logic [63:0]       ck_pad_src;
  logic              hold_cand;
  logic              hold_better;
  logic              load_ok;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa;
  fswl_pkg::entry_t  mem_wd;
  logic [63:0]       prep_old_wear;

  assign item_cmd_o = item_q.cmd;
  assign res_o      = res_q;

  assign key_addr = (op_q == fswl_pkg::OP_CUR_HOLD) ? hold_q.addr : item_q.device_address;
  assign addr_hit = (rd_q.addr == key_addr);
  assign ver_hit  = valid_q[idx_q] && addr_hit && (rd_q.version > cur_ver_q);

  always_comb begin
    any_inv   = 1'b0;
    first_inv = '0;
    for (int i = NUM_SECTORS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_inv   = 1'b1;
        first_inv = IdxW'(i);
      end
    end
  end

  assign sel_in_range = (32'(item_q.sector_sel) < 32'(NUM_SECTORS));
  assign sel_idx      = IdxW'(item_q.sector_sel);
  assign is_load      = (item_q.cmd == fswl_pkg::CMD_LOAD);

  assign ck_wear_src = is_load ? item_q.header_wear    : new_wear_q;
  assign ck_ver_src  = is_load ? item_q.header_version : new_ver_q;
  assign ck_pad_src  = is_load ? item_q.header_pad     : 64'd0;

  // A sector that does not hold its address's newest version, and whose wear is not all ones, may be reused.
  // Order among equal wear: first appearance of the address, then sector.
  assign hold_cand   = (hold_q.version != cur_ver_q) && (hold_q.wear != '1);
  assign hold_better = !best_found_q || (hold_q.wear < best_wear_q) ||
                       ((hold_q.wear == best_wear_q) && (first_idx_q < best_first_q));

  assign load_ok = (item_q.header_magic == fswl_pkg::HDR_MAGIC) &&
                   (item_q.header_wear != 64'd0) && (item_q.header_version != 64'd0) &&
                   (item_q.header_pad == 64'd0) && (item_q.header_sum == ck_q);

  assign prep_old_wear = any_inv ? 64'd0 : best_wear_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sel_idx;
    mem_wd = '{addr: item_q.device_address, version: item_q.header_version,
               wear: item_q.header_wear};
    if (op_q == fswl_pkg::OP_WR_LOAD) begin
      mem_we = sel_in_range;
    end else if (op_q == fswl_pkg::OP_WR_ALLOC) begin
      mem_we = alloc_ok_q;
      mem_wa = pick_q;
      mem_wd = '{addr: item_q.device_address, version: new_ver_q, wear: new_wear_q};
    end
  end

  // Result of the command in hand; a load echoes its header, others are zero unless found or granted.
  always_comb begin
    res_d = '0;
    case (item_q.cmd)
      fswl_pkg::CMD_LOAD: begin
        if (sel_in_range) begin
          res_d.ok          = load_ok_q;
          res_d.sector_out  = item_q.sector_sel;
          res_d.wear_out    = item_q.header_wear;
          res_d.version_out = item_q.header_version;
        end
      end
      fswl_pkg::CMD_LOOKUP: begin
        if (cur_found_q) begin
          res_d.ok          = 1'b1;
          res_d.sector_out  = 2'(cur_idx_q);
          res_d.wear_out    = cur_wear_q;
          res_d.version_out = cur_ver_q;
        end
      end
      fswl_pkg::CMD_ALLOC: begin
        if (alloc_ok_q) begin
          res_d.ok           = 1'b1;
          res_d.sector_out   = 2'(pick_q);
          res_d.wear_out     = new_wear_q;
          res_d.version_out  = new_ver_q;
          res_d.checksum_out = ck_q;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    rd_q <= entry_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= fswl_pkg::OP_NOP;
      idx_q   <= '0;
      valid_q <= '0;
    end else begin
      op_q  <= ctl_cmd_i.op;
      idx_q <= rd_idx_i;
      if (mem_we) begin
        valid_q[mem_wa] <= (op_q == fswl_pkg::OP_WR_LOAD) ? load_ok : (new_ver_q != 64'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.capture) begin
      item_q <= item_i;
    end
    case (op_q)
      fswl_pkg::OP_CUR_CLR: begin
        cur_found_q   <= 1'b0;
        cur_ver_q     <= '0;
        first_found_q <= 1'b0;
      end
      fswl_pkg::OP_CUR_ITEM, fswl_pkg::OP_CUR_HOLD: begin
        if (ver_hit) begin
          cur_found_q <= 1'b1;
          cur_ver_q   <= rd_q.version;
          cur_wear_q  <= rd_q.wear;
          cur_idx_q   <= idx_q;
        end
        if (addr_hit && !first_found_q) begin
          first_found_q <= 1'b1;
          first_idx_q   <= idx_q;
        end
      end
      fswl_pkg::OP_HOLD: begin
        hold_q        <= rd_q;
        hold_idx_q    <= idx_q;
        cur_found_q   <= 1'b0;
        cur_ver_q     <= '0;
        first_found_q <= 1'b0;
      end
      fswl_pkg::OP_BEST_CLR: begin
        best_found_q <= 1'b0;
      end
      fswl_pkg::OP_CAND: begin
        if (hold_cand && hold_better) begin
          best_found_q <= 1'b1;
          best_wear_q  <= hold_q.wear;
          best_first_q <= first_idx_q;
          best_idx_q   <= hold_idx_q;
        end
      end
      fswl_pkg::OP_PREP: begin
        pick_q     <= any_inv ? first_inv : best_idx_q;
        alloc_ok_q <= any_inv || best_found_q;
        new_ver_q  <= cur_found_q ? cur_ver_q + 64'd1 : 64'd1;
        new_wear_q <= prep_old_wear + 64'd1;
      end
      fswl_pkg::OP_CK_WEAR: begin
        ck_q <= fswl_pkg::byte_sum64(ck_wear_src);
      end
      fswl_pkg::OP_CK_VER: begin
        ck_q <= ck_q + fswl_pkg::byte_sum64(ck_ver_src);
      end
      fswl_pkg::OP_CK_FIN: begin
        ck_q <= ck_q + fswl_pkg::byte_sum64(ck_pad_src) + fswl_pkg::MAGIC_SUM +
                16'(item_q.device_address);
      end
      fswl_pkg::OP_WR_LOAD: begin
        load_ok_q <= load_ok;
      end
      fswl_pkg::OP_RES: begin
        res_q <= res_d;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/fswl_ctrl.sv */
module fswl_ctrl #(
  parameter int unsigned NUM_SECTORS = fswl_pkg::NUM_SECTORS_DEF,
  localparam int unsigned IdxW = $clog2(NUM_SECTORS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  fswl_pkg::cmd_e     item_cmd_i,
  output fswl_pkg::ctl_cmd_t ctl_cmd_o,
  output logic [IdxW-1:0]    rd_idx_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_HOLD,
    ST_INNER,
    ST_CAND,
    ST_ITEMCLR,
    ST_SCAN,
    ST_PREP,
    ST_CK_WEAR,
    ST_CK_VER,
    ST_CK_FIN,
    ST_WRITE,
    ST_RES,
    ST_DONE
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SECTORS - 1);

  state_e          state_q;
  logic [IdxW-1:0] s_q;
  logic [IdxW-1:0] t_q;
  logic            out_valid_q;
  logic            res_go;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  // The result register may be refilled once it is empty or drains this cycle.
  assign res_go      = !out_valid_q || out_ready_i;

  always_comb begin
    ctl_cmd_o = '{capture: 1'b0, op: fswl_pkg::OP_NOP};
    rd_idx_o  = '0;
    unique case (state_q)
      ST_IDLE:     ctl_cmd_o.capture = in_valid_i;
      ST_DISPATCH: begin
        unique case (item_cmd_i)
          fswl_pkg::CMD_LOOKUP: ctl_cmd_o.op = fswl_pkg::OP_CUR_CLR;
          fswl_pkg::CMD_ALLOC:  ctl_cmd_o.op = fswl_pkg::OP_BEST_CLR;
          default:              ctl_cmd_o.op = fswl_pkg::OP_NOP;
        endcase
      end
      ST_HOLD: begin
        ctl_cmd_o.op = fswl_pkg::OP_HOLD;
        rd_idx_o     = s_q;
      end
      ST_INNER: begin
        ctl_cmd_o.op = fswl_pkg::OP_CUR_HOLD;
        rd_idx_o     = t_q;
      end
      ST_CAND:     ctl_cmd_o.op = fswl_pkg::OP_CAND;
      ST_ITEMCLR:  ctl_cmd_o.op = fswl_pkg::OP_CUR_CLR;
      ST_SCAN: begin
        ctl_cmd_o.op = fswl_pkg::OP_CUR_ITEM;
        rd_idx_o     = t_q;
      end
      ST_PREP:     ctl_cmd_o.op = fswl_pkg::OP_PREP;
      ST_CK_WEAR:  ctl_cmd_o.op = fswl_pkg::OP_CK_WEAR;
      ST_CK_VER:   ctl_cmd_o.op = fswl_pkg::OP_CK_VER;
      ST_CK_FIN:   ctl_cmd_o.op = fswl_pkg::OP_CK_FIN;
      ST_WRITE: begin
        ctl_cmd_o.op = (item_cmd_i == fswl_pkg::CMD_LOAD) ? fswl_pkg::OP_WR_LOAD
                                                           : fswl_pkg::OP_WR_ALLOC;
      end
      ST_RES:      ctl_cmd_o.op = res_go ? fswl_pkg::OP_RES : fswl_pkg::OP_NOP;
      ST_DONE:     ctl_cmd_o.op = fswl_pkg::OP_NOP;
      default:     ctl_cmd_o.op = fswl_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s_q         <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          unique case (item_cmd_i)
            fswl_pkg::CMD_LOAD: state_q <= ST_CK_WEAR;
            fswl_pkg::CMD_LOOKUP: begin
              t_q     <= '0;
              state_q <= ST_SCAN;
            end
            fswl_pkg::CMD_ALLOC: begin
              s_q     <= '0;
              state_q <= ST_HOLD;
            end
            default: state_q <= ST_RES;
          endcase
        end
        ST_HOLD: begin
          t_q     <= '0;
          state_q <= ST_INNER;
        end
        ST_INNER: begin
          if (t_q == LastIdx) begin
            state_q <= ST_CAND;
          end else begin
            t_q <= t_q + 1'b1;
          end
        end
        ST_CAND: begin
          if (s_q == LastIdx) begin
            state_q <= ST_ITEMCLR;
          end else begin
            s_q     <= s_q + 1'b1;
            state_q <= ST_HOLD;
          end
        end
        ST_ITEMCLR: begin
          t_q     <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (t_q == LastIdx) begin
            state_q <= (item_cmd_i == fswl_pkg::CMD_ALLOC) ? ST_PREP : ST_RES;
          end else begin
            t_q <= t_q + 1'b1;
          end
        end
        ST_PREP:    state_q <= ST_CK_WEAR;
        ST_CK_WEAR: state_q <= ST_CK_VER;
        ST_CK_VER:  state_q <= ST_CK_FIN;
        ST_CK_FIN:  state_q <= ST_WRITE;
        ST_WRITE:   state_q <= ST_RES;
        ST_RES: begin
          if (res_go) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/flash_sector_wear_leveler_top.sv */
// Sector metadata keeper for a flash-backed emulated EEPROM.
// Slave stream: one beat is one command. tuser carries the command (load header,
// lookup address, allocate for address); tdata carries sector select, device
// address and the header fields read from flash. Master stream: one result beat
// per command (ok flag, sector, wear, version, header checksum).
// Commands run one at a time. The sector table memory is read one entry per
// cycle: allocate runs a nested pass (every sector against every sector) to find
// each sector's newest version, then one more pass for the target address.
// s_axis_tready_o is high only between commands. A finished result sits in
// an output register; while it waits the next beat is still taken, and that
// command stalls just before its result is written until the old one leaves.
// Reset clears all valid marks: every sector reads as unused, no result pending.
module flash_sector_wear_leveler_top #(
  parameter int unsigned NUM_SECTORS = fswl_pkg::NUM_SECTORS_DEF,
  localparam int unsigned IdxW = $clog2(NUM_SECTORS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata, low bit up: sector_sel[1:0], device_address[8:2], header_magic[40:9],
  // header_wear[104:41], header_version[168:105], header_pad[232:169],
  // header_sum[248:233], zero fill [255:249]
  input  logic [fswl_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [fswl_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata, low bit up: ok[0], sector_out[2:1], wear_out[66:3],
  // version_out[130:67], checksum_out[146:131], zero fill [151:147]
  output logic [fswl_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  fswl_pkg::item_t    item;
  fswl_pkg::ctl_cmd_t ctl_cmd;
  fswl_pkg::cmd_e     item_cmd;
  fswl_pkg::result_t  res;
  logic [IdxW-1:0]    rd_idx;

  // Unpack the command beat.
  assign item = '{
    cmd:            fswl_pkg::cmd_e'(s_axis_tuser_i),
    sector_sel:     s_axis_tdata_i[1:0],
    device_address: s_axis_tdata_i[8:2],
    header_magic:   s_axis_tdata_i[40:9],
    header_wear:    s_axis_tdata_i[104:41],
    header_version: s_axis_tdata_i[168:105],
    header_pad:     s_axis_tdata_i[232:169],
    header_sum:     s_axis_tdata_i[248:233]
  };

  assign m_axis_tdata_o = {5'd0, res.checksum_out, res.version_out, res.wear_out,
                           res.sector_out, res.ok};

  fswl_ctrl #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .item_cmd_i  (item_cmd),
    .ctl_cmd_o   (ctl_cmd),
    .rd_idx_o    (rd_idx)
  );

  fswl_dpath #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_cmd_i  (ctl_cmd),
    .rd_idx_i   (rd_idx),
    .item_i     (item),
    .item_cmd_o (item_cmd),
    .res_o      (res)
  );

  // One command at a time: an accepted beat closes the input until it is done.
  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a command is in progress");

  // Table reads never go past the last sector.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rd_idx} < (IdxW+1)'(NUM_SECTORS)))
    else $error("sector table read index out of range");

  // A result only shows up after the datapath formed it.
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(ctl_cmd.op == fswl_pkg::OP_RES, 2))
    else $error("result valid without a result update");

endmodule

/* tb/sv/flash_sector_wear_leveler_checker.sv */
// Watches both streams of the wear leveler, keeps a shadow of the sector
// table and checks every result beat against the oldest predicted one.
module flash_sector_wear_leveler_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  // sector_sel, device_address, header_magic, header_wear, header_version,
  // header_pad, header_sum, zero fill
  input  logic [fswl_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  // cmd
  input  logic [fswl_pkg::IN_TUSER_W-1:0]  s_tuser_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // ok, sector_out, wear_out, version_out, checksum_out, zero fill
  input  logic [fswl_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int Sectors = fswl_pkg::NUM_SECTORS_DEF;

  logic        sect_valid [Sectors];
  logic [6:0]  sect_addr  [Sectors];
  logic [63:0] sect_ver   [Sectors];
  logic [63:0] sect_wear  [Sectors];

  fswl_pkg::result_t expected_results [$];
  int      mismatch_count = 0;
  int      beat_count = 0;

  // 16-bit byte sum of the 29-byte header image.
  function automatic logic [15:0] header_checksum(input logic [63:0] wear,
                                                  input logic [63:0] ver,
                                                  input logic [6:0]  addr,
                                                  input logic [63:0] pad);
    logic [15:0] acc;
    acc = 16'(addr);
    for (int b = 0; b < 8; b++) begin
      acc = acc + 16'(wear[8*b +: 8]) + 16'(ver[8*b +: 8]) + 16'(pad[8*b +: 8]);
      if (b < 4) acc = acc + 16'(fswl_pkg::HDR_MAGIC[8*b +: 8]);
    end
    return acc;
  endfunction

  // Highest version held by a valid sector of addr; idx -1 when none.
  function automatic logic [63:0] newest_version(input logic [6:0] addr, output int idx);
    logic [63:0] top_ver;
    top_ver = '0;
    idx = -1;
    for (int s = 0; s < Sectors; s++) begin
      if (sect_valid[s] && sect_addr[s] == addr && sect_ver[s] > top_ver) begin
        top_ver = sect_ver[s];
        idx = s;
      end
    end
    return top_ver;
  endfunction

  task automatic report_failure(input string msg);
    mismatch_count = mismatch_count + 1;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_failure($sformatf("result beat %0d: %s is %h, expected %h",
                               beat_count, name, got, want));
    end
  endtask

  // Applies one command to the shadow table and returns its result.
  task automatic predict_outcome(input fswl_pkg::item_t it, output fswl_pkg::result_t res);
    int          idx;
    int          pick;
    int          n_seen;
    logic        dup;
    logic        load_ok;
    logic [6:0]  seen [Sectors];
    logic [63:0] cur;
    logic [63:0] low_wear;
    logic [63:0] old_wear;
    logic [63:0] new_ver;
    logic [63:0] new_wear;
    res = '0;
    case (it.cmd)
      fswl_pkg::CMD_LOAD: begin
        load_ok = it.header_magic == fswl_pkg::HDR_MAGIC && it.header_wear != '0 &&
                  it.header_version != '0 && it.header_pad == '0 &&
                  it.header_sum == header_checksum(it.header_wear, it.header_version,
                                                   it.device_address, it.header_pad);
        sect_valid[it.sector_sel] = load_ok;
        sect_addr[it.sector_sel]  = it.device_address;
        sect_ver[it.sector_sel]   = it.header_version;
        sect_wear[it.sector_sel]  = it.header_wear;
        res.ok          = load_ok;
        res.sector_out  = it.sector_sel;
        res.wear_out    = it.header_wear;
        res.version_out = it.header_version;
      end
      fswl_pkg::CMD_LOOKUP: begin
        cur = newest_version(it.device_address, idx);
        if (idx >= 0) begin
          res.ok          = 1'b1;
          res.sector_out  = idx[1:0];
          res.wear_out    = sect_wear[idx];
          res.version_out = cur;
        end
      end
      fswl_pkg::CMD_ALLOC: begin
        pick = -1;
        old_wear = '0;
        for (int s = 0; s < Sectors; s++) begin
          if (pick < 0 && !sect_valid[s]) pick = s;
        end
        if (pick < 0) begin
          // table full: addresses in first-appearance order, then sector order
          n_seen = 0;
          for (int s = 0; s < Sectors; s++) begin
            dup = 1'b0;
            for (int j = 0; j < n_seen; j++) begin
              if (seen[j] == sect_addr[s]) dup = 1'b1;
            end
            if (!dup) begin
              seen[n_seen] = sect_addr[s];
              n_seen = n_seen + 1;
            end
          end
          low_wear = '1;
          for (int i = 0; i < n_seen; i++) begin
            cur = newest_version(seen[i], idx);
            for (int s = 0; s < Sectors; s++) begin
              if (sect_addr[s] == seen[i] && sect_ver[s] != cur &&
                  sect_wear[s] < low_wear) begin
                low_wear = sect_wear[s];
                pick = s;
              end
            end
          end
          old_wear = low_wear;
        end
        if (pick >= 0) begin
          cur = newest_version(it.device_address, idx);
          new_ver  = (idx >= 0) ? cur + 64'd1 : 64'd1;
          new_wear = old_wear + 64'd1;
          // a wrapped version of zero is stored but never valid
          sect_valid[pick] = new_ver != '0;
          sect_addr[pick]  = it.device_address;
          sect_ver[pick]   = new_ver;
          sect_wear[pick]  = new_wear;
          res.ok           = 1'b1;
          res.sector_out   = pick[1:0];
          res.wear_out     = new_wear;
          res.version_out  = new_ver;
          res.checksum_out = header_checksum(new_wear, new_ver, it.device_address, '0);
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_command(input logic [fswl_pkg::IN_TDATA_W-1:0] tdata,
                              input logic [fswl_pkg::IN_TUSER_W-1:0] tuser);
    fswl_pkg::item_t   it;
    fswl_pkg::result_t res;
    it.cmd            = fswl_pkg::cmd_e'(tuser[1:0]);
    it.sector_sel     = tdata[1:0];
    it.device_address = tdata[8:2];
    it.header_magic   = tdata[40:9];
    it.header_wear    = tdata[104:41];
    it.header_version = tdata[168:105];
    it.header_pad     = tdata[232:169];
    it.header_sum     = tdata[248:233];
    predict_outcome(it, res);
    expected_results.push_back(res);
  endtask

  task automatic check_result(input logic [fswl_pkg::OUT_TDATA_W-1:0] tdata);
    fswl_pkg::result_t want;
    beat_count = beat_count + 1;
    if (expected_results.size() == 0) begin
      report_failure($sformatf("result beat %0d arrived with nothing expected",
                               beat_count));
    end else begin
      want = expected_results.pop_front();
      compare_field("ok",           64'(tdata[0]),       64'(want.ok));
      compare_field("sector_out",   64'(tdata[2:1]),     64'(want.sector_out));
      compare_field("wear_out",     tdata[66:3],         want.wear_out);
      compare_field("version_out",  tdata[130:67],       want.version_out);
      compare_field("checksum_out", 64'(tdata[146:131]), 64'(want.checksum_out));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Sectors; s++) begin
        sect_valid[s] = 1'b0;
        sect_addr[s]  = '0;
        sect_ver[s]   = '0;
        sect_wear[s]  = '0;
      end
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // a result always belongs to an older command, so retire it first
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i);
      if (s_tvalid_i && s_tready_i) take_command(s_tdata_i, s_tuser_i);
      pending_o    <= expected_results.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

/* tb/sv/flash_sector_wear_leveler_top_test.sv */
// Stimulus and verdict for the wear leveler. The checker beside the block
// does all prediction and comparison; this module only feeds command beats,
// throttles the result stream and reads the checker's counts at the end.
module flash_sector_wear_leveler_top_test;

  // tuser code the block must ignore (all-zero result)
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [63:0] ALL_ONES = '1;
  localparam int PHASES = 17;
  localparam int PHASE_BEATS = 100;

  typedef enum logic [1:0] {
    RX_OPEN,     // always ready
    RX_COIN,     // ready half the time
    RX_SPARSE,   // ready one cycle in four on average
    RX_CYCLIC    // fixed repeating on/off pattern
  } rx_mode_e;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic [fswl_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [fswl_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i = '0;
  logic                             m_axis_tready_i = 1'b0;
  logic                             s_axis_tready_o;
  logic                             m_axis_tvalid_o;
  logic [fswl_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  int fail_count;
  int pending;

  // sender burst state
  int burst_left = 0;
  bit steady = 1'b0;

  // receiver stall pattern state
  rx_mode_e   rx_mode = RX_OPEN;
  int         rx_left = 0;
  logic [2:0] rx_tick = '0;

  // small per-phase address pool so sectors collide and the table fills
  logic [6:0] addr_pool [4];
  int         pool_n = 1;

  flash_sector_wear_leveler_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  flash_sector_wear_leveler_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: a new stall mode each time its random hold count runs out, so result
  // beats back up against commands in flight at every stage of their work.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 3'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready_i <= 1'b1;
      RX_COIN:   m_axis_tready_i <= ($urandom_range(0, 1) == 0);
      RX_SPARSE: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready_i <= (rx_tick < 3'd3);
    endcase
  end

  // Header sum as the flash image would carry it; used to build good headers.
  function automatic logic [15:0] header_sum16(input logic [63:0] wear,
                                               input logic [63:0] ver,
                                               input logic [63:0] pad,
                                               input logic [6:0]  addr);
    logic [15:0] s;
    s = 16'(addr);
    for (int k = 0; k < 64; k += 8) begin
      s = s + 16'(wear[k +: 8]) + 16'(ver[k +: 8]) + 16'(pad[k +: 8]);
    end
    for (int k = 0; k < 32; k += 8) begin
      s = s + 16'(fswl_pkg::HDR_MAGIC[k +: 8]);
    end
    return s;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly small wear counts, with the extremes now and then.
  function automatic logic [63:0] pick_wear();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return rand64();
    if (r == 1) return ALL_ONES;
    if (r == 2) return ALL_ONES - 64'd1;
    return 64'($urandom_range(1, 24));
  endfunction

  // Small versions so addresses pile up; all-ones sets up a version wrap.
  function automatic logic [63:0] pick_version();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return rand64();
    if (r == 1) return ALL_ONES;
    return 64'($urandom_range(1, 6));
  endfunction

  function automatic logic [6:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return addr_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // Drives one command beat and waits for its handshake. tvalid stays high
  // inside a burst; a burst ends with a random gap unless the phase is steady.
  task automatic send_cmd(input logic [1:0]  cmd,
                          input logic [1:0]  sel,
                          input logic [6:0]  addr,
                          input logic [31:0] magic,
                          input logic [63:0] wear,
                          input logic [63:0] ver,
                          input logic [63:0] pad,
                          input logic [15:0] sum);
    int gap;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {7'd0, sum, pad, ver, wear, magic, addr, sel};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (steady) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(10, 45);
      else gap = $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Well-formed header: right magic, zero pad, matching sum.
  task automatic load_header(input logic [1:0] sel, input logic [6:0] addr,
                             input logic [63:0] wear, input logic [63:0] ver);
    send_cmd(fswl_pkg::CMD_LOAD, sel, addr, fswl_pkg::HDR_MAGIC, wear, ver, '0,
             header_sum16(wear, ver, '0, addr));
  endtask

  // Lookup and allocate carry junk in the unused fields; it must not matter.
  task automatic lookup(input logic [6:0] addr);
    send_cmd(fswl_pkg::CMD_LOOKUP, 2'($urandom_range(0, 3)), addr, $urandom, rand64(),
             rand64(), rand64(), 16'($urandom_range(0, 65535)));
  endtask

  task automatic allocate(input logic [6:0] addr);
    send_cmd(fswl_pkg::CMD_ALLOC, 2'($urandom_range(0, 3)), addr, $urandom, rand64(),
             rand64(), rand64(), 16'($urandom_range(0, 65535)));
  endtask

  // Hold off the sender until every outstanding result beat has come back.
  // The first edge lets the checker's count catch up with the last beat.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [63:0] w;
    logic [63:0] v;
    logic [63:0] p;
    logic [31:0] mg;
    logic [15:0] sm;
    logic [6:0]  a;
    int          r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    lookup(7'h00);                        // empty table: miss
    allocate(7'h7f);                      // first free sector, version 1
    lookup(7'h7f);
    send_cmd(CMD_UNUSED, 2'b11, 7'h7f, '1, '1, '1, '1, '1);   // ignored command
    load_header(2'd1, 7'h00, 64'd1, ALL_ONES);
    allocate(7'h00);                      // version wraps to zero, stored invalid
    lookup(7'h00);                        // still the all-ones version
    // broken headers, one flaw each
    send_cmd(fswl_pkg::CMD_LOAD, 2'd2, 7'h11, ~fswl_pkg::HDR_MAGIC, 64'd3, 64'd1, '0,
             header_sum16(64'd3, 64'd1, '0, 7'h11));
    send_cmd(fswl_pkg::CMD_LOAD, 2'd2, 7'h11, fswl_pkg::HDR_MAGIC, 64'd0, 64'd1, '0,
             header_sum16(64'd0, 64'd1, '0, 7'h11));
    send_cmd(fswl_pkg::CMD_LOAD, 2'd2, 7'h11, fswl_pkg::HDR_MAGIC, 64'd3, 64'd0, '0,
             header_sum16(64'd3, 64'd0, '0, 7'h11));
    send_cmd(fswl_pkg::CMD_LOAD, 2'd2, 7'h11, fswl_pkg::HDR_MAGIC, 64'd3, 64'd1, 64'h80,
             header_sum16(64'd3, 64'd1, 64'h80, 7'h11));
    send_cmd(fswl_pkg::CMD_LOAD, 2'd2, 7'h11, fswl_pkg::HDR_MAGIC, 64'd3, 64'd1, '0,
             header_sum16(64'd3, 64'd1, '0, 7'h11) + 16'd1);
    load_header(2'd3, 7'h7f, ALL_ONES, ALL_ONES);               // widest valid header
    // four addresses, one sector each: every sector is current, no candidate
    load_header(2'd0, 7'h10, 64'd5, 64'd1);
    load_header(2'd1, 7'h11, 64'd3, 64'd1);
    load_header(2'd2, 7'h12, 64'd3, 64'd1);
    load_header(2'd3, 7'h13, 64'd9, 64'd1);
    allocate(7'h20);
    // tie on wear: address order beats sector order (sector 2 before 1)
    load_header(2'd0, 7'h2a, 64'd9, 64'd2);
    load_header(2'd1, 7'h55, 64'd4, 64'd1);
    load_header(2'd2, 7'h2a, 64'd4, 64'd1);
    load_header(2'd3, 7'h55, 64'd9, 64'd3);
    allocate(7'h2a);
    // an all-ones wear count is never taken
    load_header(2'd1, 7'h55, ALL_ONES, 64'd1);
    allocate(7'h55);
    lookup(7'h55);
    drain();

    // ---- random part ----
    for (int phase = 0; phase < PHASES; phase++) begin
      steady = ($urandom_range(0, 3) == 0);
      pool_n = $urandom_range(2, 4);
      for (int k = 0; k < 4; k++) addr_pool[k] = 7'($urandom_range(0, 127));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        r = $urandom_range(0, 99);
        a = pick_addr();
        if (r < 33) begin
          load_header(2'($urandom_range(0, 3)), a, pick_wear(), pick_version());
        end else if (r < 43) begin
          // header with random flaws; some come out clean by chance
          w  = pick_wear();
          v  = pick_version();
          mg = fswl_pkg::HDR_MAGIC;
          p  = '0;
          if ($urandom_range(0, 3) == 0) mg = $urandom;
          if ($urandom_range(0, 3) == 0) w = '0;
          if ($urandom_range(0, 3) == 0) v = '0;
          if ($urandom_range(0, 3) == 0) begin
            p = ($urandom_range(0, 1) == 0) ? rand64() : 64'd1 << $urandom_range(0, 63);
          end
          sm = header_sum16(w, v, p, a);
          if ($urandom_range(0, 2) == 0) sm = 16'($urandom_range(0, 65535));
          send_cmd(fswl_pkg::CMD_LOAD, 2'($urandom_range(0, 3)), a, mg, w, v, p, sm);
        end else if (r < 68) begin
          lookup(a);
        end else if (r < 98) begin
          allocate(a);
        end else begin
          send_cmd(CMD_UNUSED, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                   $urandom, rand64(), rand64(), rand64(), 16'($urandom_range(0, 65535)));
        end
      end
      drain();
    end

    // allow any stray beat to show up before the verdict
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #40000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
